FILE: design/patan_pkg.sv
`timescale 1ns / 1ps
package patan_pkg;

  localparam int INPUT_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 3;

  localparam int QBITS     = 30;
  localparam int ACC_W     = QBITS + 4;
  localparam int MAG_W     = QBITS + 2;
  localparam int RATIO_W   = QBITS + 1;
  localparam int PROD_W    = MAG_W + RATIO_W;
  localparam int ROUND_SH  = QBITS - ANGLE_FRAC_BITS;

  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = (QBITS + DIV_STEPS) / DIV_STEPS;

  localparam int HORNER_STEPS = 5;
  localparam int MAC_UNITS    = HORNER_STEPS + 1;

  localparam int LATENCY = 1 + DIV_STAGES + 1 + 2 * MAC_UNITS + 3;

  localparam logic signed [ACC_W-1:0] COEF_C11 = ACC_W'(-64'sd14474544);

  localparam logic signed [ACC_W-1:0] COEF_TBL [HORNER_STEPS] = '{
    ACC_W'(64'sd61715796),
    ACC_W'(-64'sd130179461),
    ACC_W'(64'sd210062475),
    ACC_W'(-64'sd357550226),
    ACC_W'(64'sd1073737132)
  };

  localparam logic signed [ACC_W-1:0] HALF_PI_Q = ACC_W'(64'sd1686629713);
  localparam logic signed [ACC_W-1:0] PI_Q      = ACC_W'(64'sd3373259426);
  localparam logic signed [ACC_W-1:0] PI_LESS_HALF_Q = PI_Q - HALF_PI_Q;

  localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_PI =
    ANGLE_WIDTH'((PI_Q + (ACC_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH);

  typedef struct packed {
    logic signed [INPUT_WIDTH-1:0] y_in;
    logic signed [INPUT_WIDTH-1:0] x_in;
  } in_t;

  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic                          zero_input;
  } out_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic swap;
    logic xneg;
    logic yneg;
  } flags_t;

  typedef struct packed {
    flags_t                 f;
    logic [INPUT_WIDTH-1:0] hi;
    logic [INPUT_WIDTH-1:0] rem;
    logic [QBITS:0]         q;
  } div_t;

  typedef struct packed {
    flags_t                   f;
    logic [QBITS:0]           r;
    logic [QBITS:0]           r2;
    logic signed [ACC_W-1:0]  acc;
  } pipe_t;

endpackage

FILE: design/patan_div.sv
`timescale 1ns / 1ps
module patan_div
  import patan_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  in_t   in_data,
  output pipe_t ratio_o
);

  div_t  stg_r [DIV_STAGES+1];
  div_t  stg_nxt [DIV_STAGES];
  div_t  front_nxt;
  pipe_t ratio_r;
  pipe_t ratio_nxt;

  always_comb begin
    logic [INPUT_WIDTH-1:0] ya;
    logic [INPUT_WIDTH-1:0] xa;
    ya = in_data.y_in[INPUT_WIDTH-1] ? INPUT_WIDTH'(-in_data.y_in) : in_data.y_in;
    xa = in_data.x_in[INPUT_WIDTH-1] ? INPUT_WIDTH'(-in_data.x_in) : in_data.x_in;
    front_nxt.f.valid = in_valid;
    front_nxt.f.zero  = (ya == '0) && (xa == '0);
    front_nxt.f.swap  = ya > xa;
    front_nxt.f.xneg  = in_data.x_in[INPUT_WIDTH-1];
    front_nxt.f.yneg  = in_data.y_in[INPUT_WIDTH-1];
    front_nxt.hi      = (ya > xa) ? ya : xa;
    front_nxt.rem     = (ya > xa) ? xa : ya;
    front_nxt.q       = '0;
  end

  always_comb begin
    logic [INPUT_WIDTH:0] t;
    t = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      stg_nxt[s] = stg_r[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k <= QBITS) begin
          if (s * DIV_STEPS + k == 0) begin
            t = {1'b0, stg_nxt[s].rem};
          end else begin
            t = {stg_nxt[s].rem, 1'b0};
          end
          if (t >= {1'b0, stg_nxt[s].hi}) begin
            stg_nxt[s].rem = INPUT_WIDTH'(t - {1'b0, stg_nxt[s].hi});
            stg_nxt[s].q   = {stg_nxt[s].q[QBITS-1:0], 1'b1};
          end else begin
            stg_nxt[s].rem = t[INPUT_WIDTH-1:0];
            stg_nxt[s].q   = {stg_nxt[s].q[QBITS-1:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
        stg_r[s] <= '0;
      end
    end else begin
      stg_r[0] <= front_nxt;
      for (int s = 0; s < DIV_STAGES; s++) begin
        stg_r[s+1] <= stg_nxt[s];
      end
    end
  end

  always_comb begin
    logic [2*RATIO_W-1:0] sq;
    sq            = stg_r[DIV_STAGES].q * stg_r[DIV_STAGES].q;
    ratio_nxt.f   = stg_r[DIV_STAGES].f;
    ratio_nxt.r   = stg_r[DIV_STAGES].q;
    ratio_nxt.r2  = RATIO_W'(sq >> QBITS);
    ratio_nxt.acc = COEF_C11;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= '0;
    end else begin
      ratio_r <= ratio_nxt;
    end
  end

  assign ratio_o = ratio_r;

endmodule

FILE: design/patan_mac.sv
`timescale 1ns / 1ps
module patan_mac
  import patan_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  pipe_t                   pipe_i,
  input  logic signed [ACC_W-1:0] coef,
  input  logic                    sel_r,
  output pipe_t                   pipe_o
);

  pipe_t             a_r;
  logic              neg_r;
  logic [PROD_W-1:0] prod_r;
  logic              neg_nxt;
  logic [PROD_W-1:0] prod_nxt;
  pipe_t             b_r;
  pipe_t             b_nxt;

  always_comb begin
    logic [ACC_W-1:0]   mag;
    logic [RATIO_W-1:0] q;
    neg_nxt  = pipe_i.acc[ACC_W-1];
    mag      = neg_nxt ? ACC_W'(-pipe_i.acc) : pipe_i.acc;
    q        = sel_r ? pipe_i.r : pipe_i.r2;
    prod_nxt = mag[MAG_W-1:0] * q;
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
    if (!rst_n) begin
      a_r <= '0;
    end else begin
      a_r <= pipe_i;
    end
  end

  always_comb begin
    logic [PROD_W:0]          sum;
    logic signed [ACC_W-1:0]  p;
    sum       = {1'b0, prod_r} + ((PROD_W + 1)'(1) << (QBITS - 1));
    p         = ACC_W'(sum >> QBITS);
    b_nxt     = a_r;
    b_nxt.acc = (neg_r ? -p : p) + coef;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else begin
      b_r <= b_nxt;
    end
  end

  assign pipe_o = b_r;

endmodule

FILE: design/patan_out.sv
`timescale 1ns / 1ps
module patan_out
  import patan_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  pipe_t pipe_i,
  output logic  out_valid,
  output out_t  out_data
);

  flags_t                  f1_r;
  logic signed [ACC_W-1:0] v_r;
  logic signed [ACC_W-1:0] v_nxt;
  flags_t                  f2_r;
  logic                    neg_r;
  logic [ACC_W-1:0]        rnd_r;
  logic                    neg_nxt;
  logic [ACC_W-1:0]        rnd_nxt;
  logic                    valid_r;
  out_t                    data_r;
  out_t                    data_nxt;

  always_comb begin
    logic signed [ACC_W-1:0] base;
    case ({pipe_i.f.swap, pipe_i.f.xneg})
      2'b01:   base = PI_Q;
      2'b10:   base = HALF_PI_Q;
      2'b11:   base = PI_LESS_HALF_Q;
      default: base = '0;
    endcase
    v_nxt = (pipe_i.f.swap ^ pipe_i.f.xneg) ? base - pipe_i.acc : base + pipe_i.acc;
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (!rst_n) begin
      f1_r <= '0;
    end else begin
      f1_r <= pipe_i.f;
    end
  end

  always_comb begin
    logic [ACC_W-1:0] mag;
    mag     = v_r[ACC_W-1] ? ACC_W'(-v_r) : v_r;
    neg_nxt = f1_r.yneg ^ v_r[ACC_W-1];
    rnd_nxt = (mag + (ACC_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      f2_r <= '0;
    end else begin
      f2_r <= f1_r;
    end
  end

  always_comb begin
    logic [ANGLE_WIDTH-1:0] a;
    a = rnd_r[ANGLE_WIDTH-1:0];
    if (f2_r.zero) begin
      data_nxt.angle      = '0;
      data_nxt.zero_input = 1'b1;
    end else begin
      data_nxt.angle      = neg_r ? -a : a;
      data_nxt.zero_input = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= f2_r.valid;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: design/polynomial_atan2.sv
`timescale 1ns / 1ps
// Four-quadrant arctangent, fully pipelined: busy is always low, so a new (y, x)
// transaction may be started in every cycle, and each one yields its angle on
// out_data with out_valid high for one cycle. The depth is set by the ratio
// divider (two quotient bits per stage, one in the last, 16 stages), the square
// of the ratio, six two-stage multiply-add units for the polynomial and three
// stages for the quadrant fold and rounding. The receiver cannot stall:
// results must be taken in the cycle they appear. Both inputs zero give angle
// zero with zero_input set.
module polynomial_atan2
  import patan_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  pipe_t mac_q [MAC_UNITS+1];

  assign busy = 1'b0;

  patan_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_data  (in_data),
    .ratio_o  (mac_q[0])
  );

  for (genvar i = 0; i < MAC_UNITS; i++) begin : g_mac
    if (i < HORNER_STEPS) begin : g_horner
      patan_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .pipe_i (mac_q[i]),
        .coef   (COEF_TBL[i]),
        .sel_r  (1'b0),
        .pipe_o (mac_q[i+1])
      );
    end else begin : g_final
      patan_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .pipe_i (mac_q[i]),
        .coef   ('0),
        .sel_r  (1'b1),
        .pipe_o (mac_q[i+1])
      );
    end
  end

  patan_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_i    (mac_q[MAC_UNITS]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_valid_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without a started transaction");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_input) |->
      ($past(in_data.y_in, LATENCY) == '0 && $past(in_data.x_in, LATENCY) == '0
       && out_data.angle == '0))
    else $error("zero flag does not match inputs");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.angle <= ANGLE_PI && out_data.angle >= -ANGLE_PI))
    else $error("angle beyond pi");

endmodule
